// ----- hw/rtl/cvr_pkg.sv -----
// cvr_pkg: shared types, widths and codes of the complex vector reduction block
// holds the item, result and queue entry structs, the mode and register codes
// and the back end state type; depends on nothing
package cvr_pkg;

    // fixed field widths
    localparam int AMP_W      = 16;
    localparam int SCALE_W    = 18;
    localparam int ACC_W      = 48;
    localparam int FRAC_BITS  = AMP_W - 1;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

    // datapath widths of the front end
    localparam int PROD_W = SCALE_W + AMP_W;          // s * b partial product
    localparam int SB_W   = PROD_W + 1 - FRAC_BITS;   // rounded s * b
    localparam int OPD_W  = SB_W + 1;                 // multiplier operand
    localparam int MUL_W  = 2 * OPD_W;                // multiplier product

    // square root width
    localparam int ROOT_W = ACC_W / 2;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = SCALE_W;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        MODE_OVERLAP = 2'd0,
        MODE_NORM    = 2'd1,
        MODE_SQDIFF  = 2'd2,
        MODE_MAXDIFF = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE     = 2'd0,
        CFG_SCALE_RE = 2'd1,
        CFG_SCALE_IM = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_ACCUM = 2'd0,
        ST_ROOT  = 2'd1,
        ST_EMIT  = 2'd2
    } back_state_t;

    typedef struct packed {
        logic signed [AMP_W-1:0] a_re;
        logic signed [AMP_W-1:0] a_im;
        logic signed [AMP_W-1:0] b_re;
        logic signed [AMP_W-1:0] b_im;
        logic                    last;
    } in_item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] result_re;
        logic signed [ACC_W-1:0] result_im;
    } out_item_t;

    // one classified element on its way from front to back
    typedef struct packed {
        mode_t                   mode;
        logic                    last;
        logic signed [ACC_W-1:0] term_re;
        logic signed [ACC_W-1:0] term_im;
    } op_t;

endpackage

// ----- hw/rtl/cvr_front.sv -----
// cvr_front: input stage, configuration registers and product pipeline
// turns each element into one accumulate term for the back end
// depends on cvr_pkg
module cvr_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  cvr_pkg::in_item_t                   item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cvr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cvr_pkg::CFG_W-1:0]           cfg_data,
    output logic                                q_push,
    input  logic                                q_ready,
    output cvr_pkg::op_t                        q_data
);

    typedef struct packed {
        cvr_pkg::mode_t                        mode;
        logic                                  last;
        logic signed [cvr_pkg::AMP_W-1:0]      ar;
        logic signed [cvr_pkg::AMP_W-1:0]      ai;
        logic signed [cvr_pkg::AMP_W-1:0]      br;
        logic signed [cvr_pkg::AMP_W-1:0]      bi;
        logic signed [cvr_pkg::SCALE_W-1:0]    sr;
        logic signed [cvr_pkg::SCALE_W-1:0]    si;
    } stage_a_t;

    typedef struct packed {
        cvr_pkg::mode_t                        mode;
        logic                                  last;
        logic signed [cvr_pkg::AMP_W-1:0]      ar;
        logic signed [cvr_pkg::AMP_W-1:0]      ai;
        logic signed [cvr_pkg::AMP_W-1:0]      br;
        logic signed [cvr_pkg::AMP_W-1:0]      bi;
        logic signed [cvr_pkg::PROD_W-1:0]     p_rr;
        logic signed [cvr_pkg::PROD_W-1:0]     p_ii;
        logic signed [cvr_pkg::PROD_W-1:0]     p_ri;
        logic signed [cvr_pkg::PROD_W-1:0]     p_ir;
    } stage_b_t;

    typedef struct packed {
        cvr_pkg::mode_t                        mode;
        logic                                  last;
        logic signed [cvr_pkg::OPD_W-1:0]      u0;
        logic signed [cvr_pkg::OPD_W-1:0]      v0;
        logic signed [cvr_pkg::OPD_W-1:0]      u1;
        logic signed [cvr_pkg::OPD_W-1:0]      v1;
        logic signed [cvr_pkg::OPD_W-1:0]      u2;
        logic signed [cvr_pkg::OPD_W-1:0]      v2;
        logic signed [cvr_pkg::OPD_W-1:0]      u3;
        logic signed [cvr_pkg::OPD_W-1:0]      v3;
    } stage_c_t;

    typedef struct packed {
        cvr_pkg::mode_t                        mode;
        logic                                  last;
        logic signed [cvr_pkg::MUL_W-1:0]      m0;
        logic signed [cvr_pkg::MUL_W-1:0]      m1;
        logic signed [cvr_pkg::MUL_W-1:0]      m2;
        logic signed [cvr_pkg::MUL_W-1:0]      m3;
    } stage_d_t;

    // configuration
    cvr_pkg::mode_t                      mode_reg;
    logic signed [cvr_pkg::SCALE_W-1:0]  scale_re_reg;
    logic signed [cvr_pkg::SCALE_W-1:0]  scale_im_reg;

    // pipeline
    logic     va_reg, vb_reg, vc_reg, vd_reg;
    stage_a_t a_reg, a_next;
    stage_b_t b_reg, b_next;
    stage_c_t c_reg, c_next;
    stage_d_t d_reg, d_next;
    logic     advance;

    // rounding of s * b
    logic signed [cvr_pkg::PROD_W:0]   rnd_re;
    logic signed [cvr_pkg::PROD_W:0]   rnd_im;
    logic signed [cvr_pkg::SB_W-1:0]   sb_re;
    logic signed [cvr_pkg::SB_W-1:0]   sb_im;
    logic signed [cvr_pkg::OPD_W-1:0]  dr_sq;
    logic signed [cvr_pkg::OPD_W-1:0]  di_sq;
    logic signed [cvr_pkg::OPD_W-1:0]  dr_sc;
    logic signed [cvr_pkg::OPD_W-1:0]  di_sc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= cvr_pkg::MODE_OVERLAP;
            scale_re_reg <= cvr_pkg::SCALE_W'(1 << cvr_pkg::FRAC_BITS);
            scale_im_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cvr_pkg::CFG_MODE:     mode_reg     <= cvr_pkg::mode_t'(cfg_data[1:0]);
                cvr_pkg::CFG_SCALE_RE: scale_re_reg <= cfg_data;
                cvr_pkg::CFG_SCALE_IM: scale_im_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // the whole pipe moves together; it halts only when the last stage cannot
    // hand its term to the queue
    assign advance = !vd_reg || q_ready;
    assign full    = !advance;
    assign q_push  = vd_reg && q_ready;

    always_comb
    begin
        a_next.mode = mode_reg;
        a_next.last = item.last;
        a_next.ar   = item.a_re;
        a_next.ai   = item.a_im;
        a_next.br   = item.b_re;
        a_next.bi   = item.b_im;
        a_next.sr   = scale_re_reg;
        a_next.si   = scale_im_reg;
    end

    // scale products for the max mode
    always_comb
    begin
        b_next.mode = a_reg.mode;
        b_next.last = a_reg.last;
        b_next.ar   = a_reg.ar;
        b_next.ai   = a_reg.ai;
        b_next.br   = a_reg.br;
        b_next.bi   = a_reg.bi;
        b_next.p_rr = cvr_pkg::PROD_W'(a_reg.sr) * cvr_pkg::PROD_W'(a_reg.br);
        b_next.p_ii = cvr_pkg::PROD_W'(a_reg.si) * cvr_pkg::PROD_W'(a_reg.bi);
        b_next.p_ri = cvr_pkg::PROD_W'(a_reg.sr) * cvr_pkg::PROD_W'(a_reg.bi);
        b_next.p_ir = cvr_pkg::PROD_W'(a_reg.si) * cvr_pkg::PROD_W'(a_reg.br);
    end

    // round half up to the amplitude grid, then the differences
    always_comb
    begin
        rnd_re = (cvr_pkg::PROD_W+1)'(b_reg.p_rr) - (cvr_pkg::PROD_W+1)'(b_reg.p_ii)
                 + (cvr_pkg::PROD_W+1)'(cvr_pkg::ROUND_HALF);
        rnd_im = (cvr_pkg::PROD_W+1)'(b_reg.p_ri) + (cvr_pkg::PROD_W+1)'(b_reg.p_ir)
                 + (cvr_pkg::PROD_W+1)'(cvr_pkg::ROUND_HALF);
        sb_re  = rnd_re[cvr_pkg::PROD_W:cvr_pkg::FRAC_BITS];
        sb_im  = rnd_im[cvr_pkg::PROD_W:cvr_pkg::FRAC_BITS];
        dr_sc  = cvr_pkg::OPD_W'(b_reg.ar) - cvr_pkg::OPD_W'(sb_re);
        di_sc  = cvr_pkg::OPD_W'(b_reg.ai) - cvr_pkg::OPD_W'(sb_im);
        dr_sq  = cvr_pkg::OPD_W'(b_reg.ar) - cvr_pkg::OPD_W'(b_reg.br);
        di_sq  = cvr_pkg::OPD_W'(b_reg.ai) - cvr_pkg::OPD_W'(b_reg.bi);
    end

    // operand routing: term_re = u0*v0 + u1*v1, term_im = u2*v2 - u3*v3
    always_comb
    begin
        c_next.mode = b_reg.mode;
        c_next.last = b_reg.last;
        c_next.u2   = '0;
        c_next.v2   = '0;
        c_next.u3   = '0;
        c_next.v3   = '0;
        unique case (b_reg.mode)
            cvr_pkg::MODE_OVERLAP:
            begin
                c_next.u0 = cvr_pkg::OPD_W'(b_reg.br);
                c_next.v0 = cvr_pkg::OPD_W'(b_reg.ar);
                c_next.u1 = cvr_pkg::OPD_W'(b_reg.bi);
                c_next.v1 = cvr_pkg::OPD_W'(b_reg.ai);
                c_next.u2 = cvr_pkg::OPD_W'(b_reg.br);
                c_next.v2 = cvr_pkg::OPD_W'(b_reg.ai);
                c_next.u3 = cvr_pkg::OPD_W'(b_reg.bi);
                c_next.v3 = cvr_pkg::OPD_W'(b_reg.ar);
            end
            cvr_pkg::MODE_NORM:
            begin
                c_next.u0 = cvr_pkg::OPD_W'(b_reg.ar);
                c_next.v0 = cvr_pkg::OPD_W'(b_reg.ar);
                c_next.u1 = cvr_pkg::OPD_W'(b_reg.ai);
                c_next.v1 = cvr_pkg::OPD_W'(b_reg.ai);
            end
            cvr_pkg::MODE_SQDIFF:
            begin
                c_next.u0 = dr_sq;
                c_next.v0 = dr_sq;
                c_next.u1 = di_sq;
                c_next.v1 = di_sq;
            end
            cvr_pkg::MODE_MAXDIFF:
            begin
                c_next.u0 = dr_sc;
                c_next.v0 = dr_sc;
                c_next.u1 = di_sc;
                c_next.v1 = di_sc;
            end
        endcase
    end

    always_comb
    begin
        d_next.mode = c_reg.mode;
        d_next.last = c_reg.last;
        d_next.m0   = cvr_pkg::MUL_W'(c_reg.u0) * cvr_pkg::MUL_W'(c_reg.v0);
        d_next.m1   = cvr_pkg::MUL_W'(c_reg.u1) * cvr_pkg::MUL_W'(c_reg.v1);
        d_next.m2   = cvr_pkg::MUL_W'(c_reg.u2) * cvr_pkg::MUL_W'(c_reg.v2);
        d_next.m3   = cvr_pkg::MUL_W'(c_reg.u3) * cvr_pkg::MUL_W'(c_reg.v3);
    end

    always_comb
    begin
        q_data.mode    = d_reg.mode;
        q_data.last    = d_reg.last;
        q_data.term_re = cvr_pkg::ACC_W'(d_reg.m0) + cvr_pkg::ACC_W'(d_reg.m1);
        q_data.term_im = cvr_pkg::ACC_W'(d_reg.m2) - cvr_pkg::ACC_W'(d_reg.m3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (advance)
        begin
            va_reg <= push;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
        end
    end

endmodule

// ----- hw/rtl/cvr_fifo.sv -----
// cvr_fifo: short queue of classified terms between front and back
// depends on cvr_pkg
module cvr_fifo #(
    parameter int DEPTH = cvr_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          ready,
    input  cvr_pkg::op_t  data_in,
    output logic          valid,
    input  logic          pop,
    output cvr_pkg::op_t  data_out
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cvr_pkg::op_t     slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign ready    = count_reg != CNT_W'(DEPTH);
    assign valid    = count_reg != '0;
    assign data_out = slot_reg[rd_ptr_reg];
    assign do_push  = push && ready;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= data_in;
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != CNT_W'(DEPTH))
        else $error("push into a full term queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from an empty term queue");

endmodule

// ----- hw/rtl/cvr_isqrt.sv -----
// cvr_isqrt: integer square root of a 48-bit value, two radicand bits per cycle
// depends on cvr_pkg
module cvr_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cvr_pkg::ACC_W-1:0]     radicand,
    output logic                          done,
    output logic [cvr_pkg::ROOT_W-1:0]    root
);

    logic [cvr_pkg::ACC_W-1:0] rem_reg, rem_next;
    logic [cvr_pkg::ACC_W-1:0] res_reg, res_next;
    logic [cvr_pkg::ACC_W-1:0] bit_reg, bit_next;
    logic [cvr_pkg::ACC_W-1:0] trial;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    assign trial = res_reg + bit_reg;
    assign done  = done_reg;
    assign root  = res_reg[cvr_pkg::ROOT_W-1:0];

    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = radicand;
            res_next  = '0;
            bit_next  = cvr_pkg::ACC_W'(1) << (cvr_pkg::ACC_W - 2);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
                res_next = res_reg >> 1;
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("square root restarted while busy");

endmodule

// ----- hw/rtl/cvr_back.sv -----
// cvr_back: accumulators, running maximum, result formation and result register
// depends on cvr_pkg and cvr_isqrt
module cvr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  cvr_pkg::op_t       q_data,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output cvr_pkg::out_item_t result
);

    cvr_pkg::back_state_t          state_reg, state_next;
    logic [cvr_pkg::ACC_W-1:0]     sum_re_reg, sum_re_next;
    logic [cvr_pkg::ACC_W-1:0]     sum_im_reg, sum_im_next;
    logic [cvr_pkg::ACC_W-1:0]     max_reg, max_next;
    cvr_pkg::out_item_t            result_reg, result_next;
    logic                          rvalid_reg, rvalid_next;

    logic [cvr_pkg::ACC_W-1:0]     sum_re_upd, sum_im_upd, max_upd;
    logic                          out_free;
    logic                          sqrt_start, sqrt_done;
    logic [cvr_pkg::ACC_W-1:0]     sqrt_radicand;
    logic [cvr_pkg::ROOT_W-1:0]    sqrt_root;

    cvr_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_radicand),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign sum_re_upd = sum_re_reg + q_data.term_re;
    assign sum_im_upd = sum_im_reg + q_data.term_im;
    assign max_upd    = (q_data.term_re > max_reg) ? q_data.term_re : max_reg;
    assign out_free   = !rvalid_reg || pop;
    assign empty      = !rvalid_reg;
    assign result     = result_reg;

    always_comb
    begin
        state_next    = state_reg;
        sum_re_next   = sum_re_reg;
        sum_im_next   = sum_im_reg;
        max_next      = max_reg;
        result_next   = result_reg;
        rvalid_next   = rvalid_reg && !pop;
        q_pop         = 1'b0;
        sqrt_start    = 1'b0;
        sqrt_radicand = sum_re_upd;
        unique case (state_reg)
            cvr_pkg::ST_ACCUM:
            begin
                if (q_valid)
                begin
                    unique case (q_data.mode)
                        cvr_pkg::MODE_OVERLAP, cvr_pkg::MODE_SQDIFF:
                        begin
                            if (!q_data.last)
                            begin
                                q_pop       = 1'b1;
                                sum_re_next = sum_re_upd;
                                sum_im_next = sum_im_upd;
                            end
                            else if (out_free)
                            begin
                                q_pop                 = 1'b1;
                                rvalid_next           = 1'b1;
                                result_next.result_re = sum_re_upd;
                                result_next.result_im =
                                    (q_data.mode == cvr_pkg::MODE_OVERLAP) ? sum_im_upd : '0;
                                sum_re_next = '0;
                                sum_im_next = '0;
                                max_next    = '0;
                            end
                        end
                        cvr_pkg::MODE_NORM:
                        begin
                            q_pop = 1'b1;
                            if (q_data.last)
                            begin
                                sqrt_start  = 1'b1;
                                sum_re_next = '0;
                                sum_im_next = '0;
                                max_next    = '0;
                                state_next  = cvr_pkg::ST_ROOT;
                            end
                            else
                                sum_re_next = sum_re_upd;
                        end
                        cvr_pkg::MODE_MAXDIFF:
                        begin
                            q_pop         = 1'b1;
                            sqrt_radicand = max_upd;
                            if (q_data.last)
                            begin
                                sqrt_start  = 1'b1;
                                sum_re_next = '0;
                                sum_im_next = '0;
                                max_next    = '0;
                                state_next  = cvr_pkg::ST_ROOT;
                            end
                            else
                                max_next = max_upd;
                        end
                    endcase
                end
            end
            cvr_pkg::ST_ROOT:
            begin
                if (sqrt_done)
                    state_next = cvr_pkg::ST_EMIT;
            end
            cvr_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    rvalid_next           = 1'b1;
                    result_next.result_re =
                        cvr_pkg::ACC_W'(sqrt_root) << cvr_pkg::FRAC_BITS;
                    result_next.result_im = '0;
                    state_next            = cvr_pkg::ST_ACCUM;
                end
            end
            default:
                state_next = cvr_pkg::ST_ACCUM;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cvr_pkg::ST_ACCUM;
            sum_re_reg <= '0;
            sum_im_reg <= '0;
            max_reg    <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sum_re_reg <= sum_re_next;
            sum_im_reg <= sum_im_next;
            max_reg    <= max_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg && !pop |=> $stable(result_reg))
        else $error("waiting result changed before transfer");

    a_clear_during_root: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != cvr_pkg::ST_ACCUM |->
            sum_re_reg == '0 && sum_im_reg == '0 && max_reg == '0)
        else $error("accumulators not cleared while result is formed");

endmodule

// ----- hw/rtl/complex_vector_reduction.sv -----
// complex_vector_reduction: top level of the complex vector reduction block
// ties the front pipeline, the term queue and the back end together
// depends on cvr_pkg, cvr_front, cvr_fifo, cvr_back
//
//  channel   handshake             payload                 transfer when
//  -------   -------------------   ---------------------   ----------------------
//  input     push / full           item (in_item_t)        push && !full
//  result    empty / pop           result (out_item_t)     pop && !empty
//  config    cfg_valid/cfg_ready   cfg_index, cfg_data     cfg_valid && cfg_ready
//
// one element per cycle enters the four-stage front pipeline while full is low,
// and the back end folds one term per cycle into its accumulators while the
// term queue holds terms
// norm and max modes add a square root of 24 steps once per vector in the back
// end, plus the start and the handoff; elements keep arriving into the
// term queue until it fills, then full rises
// full also rises when the front pipeline's last stage finds the queue full,
// and a waiting result that is not popped stalls the back end at the next
// vector end; reset (async, active low) sets mode overlap, scale 1.0, and
// clears all accumulators and the result valid flag at once
module complex_vector_reduction #(
    parameter int QUEUE_DEPTH = cvr_pkg::QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  cvr_pkg::in_item_t              item,
    output logic                           empty,
    input  logic                           pop,
    output cvr_pkg::out_item_t             result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cvr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cvr_pkg::CFG_W-1:0]      cfg_data
);

    // front to queue
    logic          q_push;
    logic          q_ready;
    cvr_pkg::op_t  q_in;

    // queue to back
    logic          q_valid;
    logic          q_pop;
    cvr_pkg::op_t  q_out;

    // front: config registers, classification and all products
    cvr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_ready   (q_ready),
        .q_data    (q_in)
    );

    // decouples the product pipeline from the square root stall in the back
    cvr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .ready    (q_ready),
        .data_in  (q_in),
        .valid    (q_valid),
        .pop      (q_pop),
        .data_out (q_out)
    );

    // back: accumulate, compare, square root and hold the result
    cvr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ----- tb/sv/tb_complex_vector_reduction.sv -----
// tb_complex_vector_reduction: self-checking testbench for the complex vector reduction block
// drives elements and register writes, predicts each vector result and checks it on pop
// depends on cvr_pkg and complex_vector_reduction
`timescale 1ns / 100ps

module tb_complex_vector_reduction;

    // watchdog limit in cycles without any transfer
    localparam int STALL_LIMIT   = 4000;
    // cycles for the front pipeline, term queue and square root to settle
    localparam int DRAIN_CYCLES  = 64;
    localparam int MAX_REPORTS   = 10;

    logic                          clk = 1'b1;
    logic                          rst_n = 1'b0;
    logic                          push = 1'b0;
    logic                          full;
    cvr_pkg::in_item_t             item = '0;
    logic                          empty;
    logic                          pop = 1'b0;
    cvr_pkg::out_item_t            result;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [cvr_pkg::CFG_IDX_W-1:0] cfg_index = cvr_pkg::CFG_MODE;
    logic [cvr_pkg::CFG_W-1:0]     cfg_data = '0;

    // idle rates in percent for the sending and the popping side
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int mismatch_count = 0;
    int stall_cycles = 0;

    // predictor state: registers and accumulators as the block should hold them
    cvr_pkg::mode_t                     cur_mode;
    logic signed [cvr_pkg::SCALE_W-1:0] scale_re_q;
    logic signed [cvr_pkg::SCALE_W-1:0] scale_im_q;
    logic [cvr_pkg::ACC_W-1:0]          acc_re;
    logic [cvr_pkg::ACC_W-1:0]          acc_im;
    logic [cvr_pkg::ACC_W-1:0]          peak_sq;

    // results owed by the block, oldest first
    cvr_pkg::out_item_t pending_results[$];

    complex_vector_reduction i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // floor of the square root of a 48-bit value, one result bit per step
    function automatic logic [cvr_pkg::ACC_W-1:0] floor_root(
        input logic [cvr_pkg::ACC_W-1:0] v);
        logic [cvr_pkg::ROOT_W-1:0] root;
        logic [cvr_pkg::ROOT_W-1:0] trial;
        root = '0;
        for (int i = cvr_pkg::ROOT_W - 1; i >= 0; i--)
        begin
            trial = root | (cvr_pkg::ROOT_W'(1) << i);
            if (cvr_pkg::ACC_W'(trial) * cvr_pkg::ACC_W'(trial) <= v)
                root = trial;
        end
        return cvr_pkg::ACC_W'(root);
    endfunction

    // fold one accepted element into the accumulators of the current mode;
    // on the last element queue the vector result and clear everything
    task automatic fold_element(input cvr_pkg::in_item_t e);
        longint ar, ai, br, bi, sb_re, sb_im, dr, di;
        logic [cvr_pkg::ACC_W-1:0] mag_sq;
        cvr_pkg::out_item_t r;
        ar = e.a_re;
        ai = e.a_im;
        br = e.b_re;
        bi = e.b_im;
        case (cur_mode)
            cvr_pkg::MODE_OVERLAP:
            begin
                // conj(b) * a
                acc_re = acc_re + cvr_pkg::ACC_W'(br * ar + bi * ai);
                acc_im = acc_im + cvr_pkg::ACC_W'(br * ai - bi * ar);
            end
            cvr_pkg::MODE_NORM:
                acc_re = acc_re + cvr_pkg::ACC_W'(ar * ar + ai * ai);
            cvr_pkg::MODE_SQDIFF:
            begin
                dr = ar - br;
                di = ai - bi;
                acc_re = acc_re + cvr_pkg::ACC_W'(dr * dr + di * di);
            end
            default:
            begin
                // s * b with its 15 fraction bits rounded off half up
                sb_re = (longint'(scale_re_q) * br - longint'(scale_im_q) * bi
                         + cvr_pkg::ROUND_HALF) >>> cvr_pkg::FRAC_BITS;
                sb_im = (longint'(scale_re_q) * bi + longint'(scale_im_q) * br
                         + cvr_pkg::ROUND_HALF) >>> cvr_pkg::FRAC_BITS;
                dr = ar - sb_re;
                di = ai - sb_im;
                mag_sq = cvr_pkg::ACC_W'(dr * dr + di * di);
                if (mag_sq > peak_sq)
                    peak_sq = mag_sq;
            end
        endcase
        if (e.last)
        begin
            r.result_im = '0;
            case (cur_mode)
                cvr_pkg::MODE_OVERLAP:
                begin
                    r.result_re = acc_re;
                    r.result_im = acc_im;
                end
                cvr_pkg::MODE_NORM:
                    r.result_re = floor_root(acc_re) << cvr_pkg::FRAC_BITS;
                cvr_pkg::MODE_SQDIFF:
                    r.result_re = acc_re;
                default:
                    r.result_re = floor_root(peak_sq) << cvr_pkg::FRAC_BITS;
            endcase
            pending_results = {pending_results, r};
            acc_re = '0;
            acc_im = '0;
            peak_sq = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    function automatic cvr_pkg::in_item_t make_element(input int ar,
                                                       input int ai,
                                                       input int br,
                                                       input int bi,
                                                       input logic lst);
        cvr_pkg::in_item_t e;
        e.a_re = cvr_pkg::AMP_W'(ar);
        e.a_im = cvr_pkg::AMP_W'(ai);
        e.b_re = cvr_pkg::AMP_W'(br);
        e.b_im = cvr_pkg::AMP_W'(bi);
        e.last = lst;
        return e;
    endfunction

    // mostly uniform amplitudes, with the extremes and zero mixed in
    function automatic int rand_amp();
        case ($urandom_range(9))
            0:       return -(1 << (cvr_pkg::AMP_W - 1));
            1:       return (1 << (cvr_pkg::AMP_W - 1)) - 1;
            2:       return 0;
            default: return int'($urandom_range((1 << cvr_pkg::AMP_W) - 1))
                            - (1 << (cvr_pkg::AMP_W - 1));
        endcase
    endfunction

    function automatic logic [cvr_pkg::CFG_W-1:0] rand_scale();
        case ($urandom_range(7))
            0:       return {1'b1, {(cvr_pkg::CFG_W-1){1'b0}}};
            1:       return {1'b0, {(cvr_pkg::CFG_W-1){1'b1}}};
            2:       return cvr_pkg::CFG_W'(1) << cvr_pkg::FRAC_BITS;
            default: return cvr_pkg::CFG_W'($urandom);
        endcase
    endfunction

    // one element transfer; the sender may idle first, push stays high when
    // the next call follows right away
    task automatic send_element(input cvr_pkg::in_item_t e);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= e;
        do
            @(posedge clk);
        while (full);
        fold_element(e);
    endtask

    // stop sending, wait for every owed result, then let the pipeline and the
    // square root settle so a register write cannot race an element in flight
    task automatic wait_idle();
        @(negedge clk);
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cvr_pkg::cfg_reg_t idx,
                             input logic [cvr_pkg::CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            cvr_pkg::CFG_MODE:     cur_mode = cvr_pkg::mode_t'(data[1:0]);
            cvr_pkg::CFG_SCALE_RE: scale_re_q = data;
            cvr_pkg::CFG_SCALE_IM: scale_im_q = data;
            default:               ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side: random pop, field compare, watchdog
    // ------------------------------------------------------------------

    always @(negedge clk)
        pop <= ($urandom_range(99) >= recv_idle_pct);

    task automatic report_mismatch(input string what,
                                   input logic signed [cvr_pkg::ACC_W-1:0] want,
                                   input logic signed [cvr_pkg::ACC_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%t %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    always @(posedge clk)
    begin
        cvr_pkg::out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%t unexpected result re %0d im %0d", $realtime,
                             result.result_re, result.result_im);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.result_re !== want.result_re)
                    report_mismatch("result_re", want.result_re, result.result_re);
                if (result.result_im !== want.result_im)
                    report_mismatch("result_im", want.result_im, result.result_im);
            end
        end
    end

    // any transfer on any channel resets the stall count
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("complex_vector_reduction: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset mode is overlap; extremes of every amplitude, and a vector that
    // holds only its last element
    task automatic test_overlap_extremes();
        send_element(make_element(-32768, -32768, -32768, -32768, 1'b0));
        send_element(make_element(32767, 32767, 32767, -32768, 1'b0));
        send_element(make_element(32767, -32768, -32768, 32767, 1'b1));
        send_element(make_element(-32768, 32767, 32767, -32768, 1'b1));
    endtask

    // max mode with the reset scale of 1.0
    task automatic test_default_scale_max();
        wait_idle();
        write_reg(cvr_pkg::CFG_MODE, cvr_pkg::CFG_W'(cvr_pkg::MODE_MAXDIFF));
        send_element(make_element(32767, -32768, -32768, 32767, 1'b0));
        send_element(make_element(0, 0, 0, 0, 1'b0));
        send_element(make_element(-32768, -32768, 32767, 32767, 1'b1));
    endtask

    // norm, including the root of zero, and squared difference at the extremes
    task automatic test_norm_and_sqdiff();
        wait_idle();
        write_reg(cvr_pkg::CFG_MODE, cvr_pkg::CFG_W'(cvr_pkg::MODE_NORM));
        send_element(make_element(-32768, -32768, 0, 0, 1'b0));
        send_element(make_element(32767, 32767, -1, -1, 1'b1));
        send_element(make_element(0, 0, 5, 5, 1'b1));
        wait_idle();
        write_reg(cvr_pkg::CFG_MODE, cvr_pkg::CFG_W'(cvr_pkg::MODE_SQDIFF));
        send_element(make_element(-32768, -32768, 32767, 32767, 1'b0));
        send_element(make_element(32767, -32768, -32768, 32767, 1'b1));
    endtask

    // complex scale at both ends of its range, and a zero scale
    task automatic test_scale_extremes();
        wait_idle();
        write_reg(cvr_pkg::CFG_MODE, cvr_pkg::CFG_W'(cvr_pkg::MODE_MAXDIFF));
        write_reg(cvr_pkg::CFG_SCALE_RE, 18'h20000);
        write_reg(cvr_pkg::CFG_SCALE_IM, 18'h1ffff);
        send_element(make_element(-32768, 32767, -32768, -32768, 1'b0));
        send_element(make_element(32767, -32768, 32767, 32767, 1'b1));
        wait_idle();
        write_reg(cvr_pkg::CFG_SCALE_RE, 18'h1ffff);
        write_reg(cvr_pkg::CFG_SCALE_IM, 18'h20000);
        send_element(make_element(32767, 32767, -32768, 32767, 1'b1));
        wait_idle();
        write_reg(cvr_pkg::CFG_SCALE_RE, '0);
        write_reg(cvr_pkg::CFG_SCALE_IM, '0);
        send_element(make_element(-32768, -32768, 1, 1, 1'b1));
    endtask

    // each element feeds the accumulator of the mode it sees; the result
    // takes the mode current at the last element
    task automatic test_mode_change_mid_vector();
        wait_idle();
        write_reg(cvr_pkg::CFG_MODE, cvr_pkg::CFG_W'(cvr_pkg::MODE_OVERLAP));
        send_element(make_element(1000, -2000, 3000, -4000, 1'b0));
        send_element(make_element(-32768, 32767, 32767, -32768, 1'b0));
        wait_idle();
        write_reg(cvr_pkg::CFG_MODE, cvr_pkg::CFG_W'(cvr_pkg::MODE_NORM));
        send_element(make_element(12345, -23456, 0, 0, 1'b1));
        wait_idle();
        write_reg(cvr_pkg::CFG_MODE, cvr_pkg::CFG_W'(cvr_pkg::MODE_SQDIFF));
        send_element(make_element(-20000, 15000, 9000, -7000, 1'b0));
        wait_idle();
        write_reg(cvr_pkg::CFG_MODE, cvr_pkg::CFG_W'(cvr_pkg::MODE_MAXDIFF));
        send_element(make_element(500, 600, -700, 800, 1'b1));
    endtask

    // well-formed vectors of random content; now and then the registers are
    // rewritten between vectors, and rarely the mode inside a vector
    task automatic test_random_vectors(input int n_elements);
        int sent;
        int len;
        sent = 0;
        while (sent < n_elements)
        begin
            if ($urandom_range(3) == 0)
            begin
                wait_idle();
                if ($urandom_range(1))
                    write_reg(cvr_pkg::CFG_MODE, cvr_pkg::CFG_W'($urandom));
                if ($urandom_range(1))
                    write_reg(cvr_pkg::CFG_SCALE_RE, rand_scale());
                if ($urandom_range(1))
                    write_reg(cvr_pkg::CFG_SCALE_IM, rand_scale());
            end
            // mostly short vectors, a few longer ones
            len = ($urandom_range(9) == 0) ? $urandom_range(32, 8) : $urandom_range(6, 1);
            for (int k = 0; k < len; k++)
            begin
                if (k > 0 && k == len - 1 && $urandom_range(15) == 0)
                begin
                    wait_idle();
                    write_reg(cvr_pkg::CFG_MODE, cvr_pkg::CFG_W'($urandom_range(3)));
                end
                send_element(make_element(rand_amp(), rand_amp(), rand_amp(), rand_amp(),
                                          k == len - 1));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        // predictor starts from the reset state
        cur_mode   = cvr_pkg::MODE_OVERLAP;
        scale_re_q = cvr_pkg::CFG_W'(1) << cvr_pkg::FRAC_BITS;
        scale_im_q = '0;
        acc_re     = '0;
        acc_im     = '0;
        peak_sq    = '0;

        // sender idles lightly, receiver heavily
        send_idle_pct = 14;
        recv_idle_pct = 45;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_overlap_extremes();
        test_default_scale_max();
        test_norm_and_sqdiff();
        test_scale_extremes();
        test_mode_change_mid_vector();
        test_random_vectors(140);

        // the other way round
        send_idle_pct = 45;
        recv_idle_pct = 14;
        test_random_vectors(140);

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_vectors(140);

        wait_idle();
        if (mismatch_count == 0)
            $display("complex_vector_reduction: match");
        else
            $display("complex_vector_reduction: mismatch");
        $finish;
    end

endmodule
